### rtl/wbs_pkg.sv
// Shared constants, codes and types of the word break segmenter.
// Used by word_break_segmenter; depends on nothing.
`timescale 1ns / 1ps

package wbs_pkg;

  // Longest dictionary word and number of dictionary slots
  localparam int MAX_WORD_LEN = 20;
  localparam int DICT_WORDS   = 64;

  // Derived widths
  localparam int LEN_W     = $clog2(MAX_WORD_LEN + 1);
  localparam int CNT_W     = $clog2(DICT_WORDS + 1);
  localparam int IDX_W     = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;
  localparam int WIN_IDX_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int REACH_W   = MAX_WORD_LEN + 1;

  // Stream beat widths
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_DICT  = 2'd0,
    OP_TEXT  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Dictionary load status codes
  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_FULL = 2'd1,
    ERR_LONG = 2'd2
  } err_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_FIN  = 2'd2
  } state_t;

endpackage

### rtl/word_break_segmenter.sv
// Word break segmenter: dictionary store, text window and scan sequencer.
// Depends on wbs_pkg.
`timescale 1ns / 1ps

// Loads dictionary words one character per beat (op 0, tlast on the last
// character), then checks text characters (op 1) one per beat and answers
// for each whether the text so far splits into dictionary words; tlast on a
// text character ends the text and its answer is final. op 2 empties the
// dictionary. Every input beat yields exactly one output beat. Dictionary,
// clear and unused-op beats are answered without a scan. For a text
// character the sequencer reads one stored word per cycle from the dictionary
// memory and a single comparator checks it against the last characters of the
// text, so every word passes through that one read port. The block takes no
// input while a text character is being scanned. No clearing pass is needed
// after reset.
module word_break_segmenter (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input beats
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [wbs_pkg::IN_DATA_W-1:0] in_tdata,   // [1:0] op, [9:2] symbol
  input  logic                          in_tlast,   // last char of word or text
  // Result beats
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [wbs_pkg::OUT_DATA_W-1:0] out_tdata, // [0] prefix_ok, [2:1] load_error
  output logic                          out_tlast   // done_res
);

  // Unpack input beat
  wbs_pkg::op_t in_op;
  logic [7:0]   in_symbol;
  logic         in_fire;

  assign in_op     = wbs_pkg::op_t'(in_tdata[1:0]);
  assign in_symbol = in_tdata[9:2];
  assign in_fire   = in_tvalid & in_tready;

  // Control state
  wbs_pkg::state_t                state_r, state_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [wbs_pkg::CNT_W-1:0]      dict_count_r, dict_count_nxt;
  logic [wbs_pkg::LEN_W-1:0]      load_len_r, load_len_nxt;
  logic                           overlong_r, overlong_nxt;
  logic [wbs_pkg::REACH_W-1:0]    reach_r, reach_nxt;
  logic [wbs_pkg::CNT_W-1:0]      issue_idx_r, issue_idx_nxt;
  logic                           rd_vld_r, rd_vld_nxt;
  logic                           hit_r, hit_nxt;
  logic                           text_last_r, text_last_nxt;

  // Payload registers
  logic                           out_ok_r, out_ok_nxt;
  logic                           out_done_r, out_done_nxt;
  wbs_pkg::err_t                  out_err_r, out_err_nxt;
  logic [7:0]                     window_r [wbs_pkg::MAX_WORD_LEN];
  logic [7:0]                     window_nxt [wbs_pkg::MAX_WORD_LEN];

  // Dictionary memories and their registered read data
  logic [wbs_pkg::MAX_WORD_LEN-1:0][7:0] dict_mem [wbs_pkg::DICT_WORDS];
  logic [wbs_pkg::LEN_W-1:0]             len_mem  [wbs_pkg::DICT_WORDS];
  logic [wbs_pkg::MAX_WORD_LEN-1:0][7:0] rd_row_r;
  logic [wbs_pkg::LEN_W-1:0]             rd_len_r;

  logic chr_we;
  logic len_we;
  logic rd_en;
  logic scan_end;

  // Comparator on the word just read
  logic [wbs_pkg::MAX_WORD_LEN-1:0] byte_ok;
  logic [wbs_pkg::LEN_W-1:0]        len_m1;
  logic                             word_hit;

  // Dictionary load decode
  logic                             ld_overlong;

  // Output port drive
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_done_r;
  assign out_tdata  = {{(wbs_pkg::OUT_DATA_W-3){1'b0}}, out_err_r, out_ok_r};

  // Scan is over once every word has been read and compared
  assign scan_end = (issue_idx_r == dict_count_r) && !rd_vld_r;

  // Per-character compare: word char k against window position len-1-k
  always_comb begin
    logic [wbs_pkg::LEN_W-1:0] sel;
    sel = '0;
    len_m1 = rd_len_r - wbs_pkg::LEN_W'(1);
    for (int k = 0; k < wbs_pkg::MAX_WORD_LEN; k++) begin
      sel = len_m1 - wbs_pkg::LEN_W'(k);
      byte_ok[k] = (wbs_pkg::LEN_W'(k) >= rd_len_r) ||
                   (rd_row_r[k] == window_r[sel[wbs_pkg::WIN_IDX_W-1:0]]);
    end
    word_hit = (rd_len_r != '0) &&
               (rd_len_r <= wbs_pkg::LEN_W'(wbs_pkg::MAX_WORD_LEN)) &&
               reach_r[len_m1] && (&byte_ok);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wbs_pkg::S_IDLE: begin
        if (in_fire && in_op == wbs_pkg::OP_TEXT) state_nxt = wbs_pkg::S_SCAN;
      end
      wbs_pkg::S_SCAN: begin
        if (scan_end) state_nxt = wbs_pkg::S_FIN;
      end
      wbs_pkg::S_FIN: begin
        state_nxt = wbs_pkg::S_IDLE;
      end
      default: begin
        state_nxt = wbs_pkg::S_IDLE;
      end
    endcase
  end

  // Handshake, datapath and memory controls
  always_comb begin
    in_tready      = (state_r == wbs_pkg::S_IDLE) && (!out_valid_r || out_tready);
    out_valid_nxt  = out_valid_r;
    out_ok_nxt     = out_ok_r;
    out_done_nxt   = out_done_r;
    out_err_nxt    = out_err_r;
    dict_count_nxt = dict_count_r;
    load_len_nxt   = load_len_r;
    overlong_nxt   = overlong_r;
    reach_nxt      = reach_r;
    issue_idx_nxt  = issue_idx_r;
    rd_vld_nxt     = rd_vld_r;
    hit_nxt        = hit_r;
    text_last_nxt  = text_last_r;
    window_nxt     = window_r;
    chr_we         = 1'b0;
    len_we         = 1'b0;
    rd_en          = 1'b0;
    ld_overlong    = overlong_r ||
                     (load_len_r >= wbs_pkg::LEN_W'(wbs_pkg::MAX_WORD_LEN));

    // Output beat taken downstream
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      wbs_pkg::S_IDLE: begin
        if (in_fire) begin
          out_ok_nxt   = 1'b0;
          out_done_nxt = 1'b0;
          out_err_nxt  = wbs_pkg::ERR_NONE;
          case (in_op)
            wbs_pkg::OP_DICT: begin
              out_valid_nxt = 1'b1;
              overlong_nxt  = ld_overlong;
              if (!ld_overlong) begin
                chr_we       = dict_count_r < wbs_pkg::CNT_W'(wbs_pkg::DICT_WORDS);
                load_len_nxt = load_len_r + wbs_pkg::LEN_W'(1);
              end
              // End of word: store length or report the drop
              if (in_tlast) begin
                if (ld_overlong) begin
                  out_err_nxt = wbs_pkg::ERR_LONG;
                end else if (dict_count_r >= wbs_pkg::CNT_W'(wbs_pkg::DICT_WORDS)) begin
                  out_err_nxt = wbs_pkg::ERR_FULL;
                end else begin
                  len_we         = 1'b1;
                  dict_count_nxt = dict_count_r + wbs_pkg::CNT_W'(1);
                end
                load_len_nxt = '0;
                overlong_nxt = 1'b0;
              end
            end
            wbs_pkg::OP_TEXT: begin
              window_nxt[0] = in_symbol;
              for (int i = 1; i < wbs_pkg::MAX_WORD_LEN; i++) begin
                window_nxt[i] = window_r[i-1];
              end
              hit_nxt       = 1'b0;
              issue_idx_nxt = '0;
              rd_vld_nxt    = 1'b0;
              text_last_nxt = in_tlast;
            end
            wbs_pkg::OP_CLEAR: begin
              out_valid_nxt  = 1'b1;
              dict_count_nxt = '0;
              load_len_nxt   = '0;
              overlong_nxt   = 1'b0;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      wbs_pkg::S_SCAN: begin
        // Issue one word read per cycle
        if (issue_idx_r < dict_count_r) begin
          rd_en         = 1'b1;
          issue_idx_nxt = issue_idx_r + wbs_pkg::CNT_W'(1);
          rd_vld_nxt    = 1'b1;
        end else begin
          rd_vld_nxt = 1'b0;
        end
        // Compare the word read last cycle
        if (rd_vld_r) hit_nxt = hit_r | word_hit;
      end
      wbs_pkg::S_FIN: begin
        out_valid_nxt = 1'b1;
        out_ok_nxt    = hit_r;
        out_done_nxt  = text_last_r;
        out_err_nxt   = wbs_pkg::ERR_NONE;
        if (text_last_r) begin
          reach_nxt = wbs_pkg::REACH_W'(1);
        end else begin
          reach_nxt = {reach_r[wbs_pkg::MAX_WORD_LEN-1:0], hit_r};
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wbs_pkg::S_IDLE;
      out_valid_r  <= 1'b0;
      dict_count_r <= '0;
      load_len_r   <= '0;
      overlong_r   <= 1'b0;
      reach_r      <= wbs_pkg::REACH_W'(1);
      issue_idx_r  <= '0;
      rd_vld_r     <= 1'b0;
      hit_r        <= 1'b0;
      text_last_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      dict_count_r <= dict_count_nxt;
      load_len_r   <= load_len_nxt;
      overlong_r   <= overlong_nxt;
      reach_r      <= reach_nxt;
      issue_idx_r  <= issue_idx_nxt;
      rd_vld_r     <= rd_vld_nxt;
      hit_r        <= hit_nxt;
      text_last_r  <= text_last_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    out_ok_r   <= out_ok_nxt;
    out_done_r <= out_done_nxt;
    out_err_r  <= out_err_nxt;
    window_r   <= window_nxt;
  end

  // Length of the word that ends on this beat
  function automatic logic [wbs_pkg::LEN_W-1:0] load_len_nxt_word();
    logic [wbs_pkg::LEN_W-1:0] len;
    len = load_len_r + wbs_pkg::LEN_W'(1);
    return len;
  endfunction

  // Dictionary memories: byte write while loading, one row read per scan cycle
  always_ff @(posedge clk) begin
    if (chr_we) begin
      dict_mem[dict_count_r[wbs_pkg::IDX_W-1:0]][load_len_r[wbs_pkg::WIN_IDX_W-1:0]]
        <= in_symbol;
    end
    if (len_we) begin
      len_mem[dict_count_r[wbs_pkg::IDX_W-1:0]] <= load_len_nxt_word();
    end
    if (rd_en) begin
      rd_row_r <= dict_mem[issue_idx_r[wbs_pkg::IDX_W-1:0]];
      rd_len_r <= len_mem[issue_idx_r[wbs_pkg::IDX_W-1:0]];
    end
  end

  // Checks
  a_no_result_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wbs_pkg::S_SCAN) |-> !out_valid_r)
    else $error("result pending while scanning");

  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    issue_idx_r <= dict_count_r || state_r != wbs_pkg::S_SCAN)
    else $error("scan index beyond dictionary count");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    dict_count_r <= wbs_pkg::CNT_W'(wbs_pkg::DICT_WORDS))
    else $error("dictionary count overflow");

  a_load_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    load_len_r <= wbs_pkg::LEN_W'(wbs_pkg::MAX_WORD_LEN))
    else $error("load length overflow");

  a_text_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wbs_pkg::S_FIN && text_last_r) |=>
      (reach_r == wbs_pkg::REACH_W'(1) && out_valid_r && out_tlast))
    else $error("end of text did not restart reachability");

endmodule
